// ===== rtl/mjt_pkg.sv =====
package mjt_pkg;

   localparam int DATA_W = 32;
   localparam int TAU_W  = 25;
   localparam int FRAC_W = 24;
   localparam int POW_N  = 5;
   localparam int DIV_W  = 55;
   localparam int DVS_W  = 64;
   localparam int OUT_W  = 48;
   localparam int ADDR_W = 3;

   localparam logic REG_START_TIME = 1'b0;
   localparam logic REG_DURATION   = 1'b1;

   typedef struct packed {
      logic                     prior;
      logic                     after;
      logic signed [DATA_W-1:0] q0;
      logic signed [DATA_W-1:0] q1;
      logic signed [DATA_W:0]   delta;
      logic                     last;
   } base_type;

   typedef logic [POW_N-1:0][TAU_W-1:0] pow_type;

   typedef struct packed {
      logic                     window;
      logic                     last;
      logic signed [DATA_W-1:0] pos;
      logic                     vsign;
      logic                     asign;
      logic [DIV_W-1:0]         vnum;
      logic [DIV_W-1:0]         anum;
      logic [DVS_W-1:0]         vrem;
      logic [DVS_W-1:0]         arem;
   } div_item_type;

   typedef struct packed {
      logic [DVS_W-1:0] rem;
      logic [DIV_W-1:0] num;
   } div_state_type;

   // one restoring step: shift in the next dividend bit, quotient bit enters at the bottom
   function automatic div_state_type div_step(input logic [DVS_W-1:0] rem,
                                              input logic [DIV_W-1:0] num,
                                              input logic [DVS_W-1:0] dvs);
      logic [DVS_W:0] trial;
      div_state_type  res;
      trial   = {rem, num[DIV_W-1]};
      res.num = {num[DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs}) begin
         trial      = trial - {1'b0, dvs};
         res.num[0] = 1'b1;
      end
      res.rem = trial[DVS_W-1:0];
      return res;
   endfunction

   function automatic logic [OUT_W-1:0] sat_out(input logic sign, input logic [DIV_W-1:0] mag);
      logic [DIV_W-1:0] pos_lim;
      logic [DIV_W-1:0] neg;
      logic [OUT_W-1:0] res;
      pos_lim = {{(DIV_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
      neg     = ~mag + {{(DIV_W-1){1'b0}}, 1'b1};
      if (!sign) begin
         res = (mag > pos_lim) ? {1'b0, {(OUT_W-1){1'b1}}} : mag[OUT_W-1:0];
      end else begin
         res = (mag > pos_lim + {{(DIV_W-1){1'b0}}, 1'b1}) ? {1'b1, {(OUT_W-1){1'b0}}}
                                                           : neg[OUT_W-1:0];
      end
      return res;
   endfunction

endpackage

// ===== rtl/mjt_if.sv =====
interface mjt_req_if;
   logic               valid;
   logic               ready;
   logic [31:0]        sample_time;
   logic signed [31:0] joint_start;
   logic signed [31:0] joint_end;
   logic               last_joint;

   modport source(output valid, sample_time, joint_start, joint_end, last_joint, input ready);
   modport sink(input valid, sample_time, joint_start, joint_end, last_joint, output ready);
endinterface

interface mjt_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] position;
   logic signed [47:0] velocity;
   logic signed [47:0] acceleration;
   logic               last_out;

   modport source(output valid, position, velocity, acceleration, last_out, input ready);
   modport sink(input valid, position, velocity, acceleration, last_out, output ready);
endinterface

// ===== rtl/mjt_div_pipe.sv =====
module mjt_div_pipe import mjt_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic             in_valid,
   input  div_item_type     in_item,
   input  logic [DVS_W-1:0] vel_divisor,
   input  logic [DVS_W-1:0] acc_divisor,
   output logic             out_valid,
   output div_item_type     out_item
);

   logic         dv_vld_ff [0:DIV_W-1];
   div_item_type dv_ff     [0:DIV_W-1];

   for (genvar k = 0; k < DIV_W; k++) begin : g_stage
      logic          vld_prev;
      div_item_type  item_prev;
      div_item_type  item_in;
      div_state_type vstep;
      div_state_type astep;

      if (k == 0) begin : g_first
         assign vld_prev  = in_valid;
         assign item_prev = in_item;
      end else begin : g_next
         assign vld_prev  = dv_vld_ff[k-1];
         assign item_prev = dv_ff[k-1];
      end

      always_comb begin
         vstep        = div_step(item_prev.vrem, item_prev.vnum, vel_divisor);
         astep        = div_step(item_prev.arem, item_prev.anum, acc_divisor);
         item_in      = item_prev;
         item_in.vrem = vstep.rem;
         item_in.vnum = vstep.num;
         item_in.arem = astep.rem;
         item_in.anum = astep.num;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_vld_ff[k] <= 1'b0;
         end else if (advance) begin
            dv_vld_ff[k] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            dv_ff[k] <= item_in;
         end
      end
   end

   assign out_valid = dv_vld_ff[DIV_W-1];
   assign out_item  = dv_ff[DIV_W-1];

endmodule

// ===== rtl/minimum_jerk_trajectory_eval.sv =====
// channel   | dir | fields
// req_chan  | in  | sample_time, joint_start, joint_end, last_joint
// rsp_chan  | out | position, velocity, acceleration, last_out
// csr apb   | in  | start_time at 0x0, duration at 0x4
//
// one item per cycle unless the output stalls; stages: input stage, 25 tau divide steps,
// 4 power products, polynomial, span products, sign/magnitude prep, 55 divide
// steps of the rate divider, output register.
// synchronous reset clears valid bits, start_time to 0 and duration to 1.
// a stalled output freezes the whole pipeline; nothing is dropped or repeated.
module minimum_jerk_trajectory_eval import mjt_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   mjt_req_if.sink           req_chan,
   mjt_rsp_if.source         rsp_chan,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   logic [DATA_W-1:0] start_time_ff;
   logic [DATA_W-1:0] duration_ff;
   logic [DATA_W-1:0] d_eff;
   logic [DVS_W-1:0]  d2_ff;
   logic              adv;
   logic              out_valid_ff;

   assign pready = 1'b1;
   assign d_eff  = (duration_ff == '0) ? {{(DATA_W-1){1'b0}}, 1'b1} : duration_ff;
   assign adv    = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_time_ff <= '0;
         duration_ff   <= {{(DATA_W-1){1'b0}}, 1'b1};
      end else if (psel && penable && pwrite) begin
         unique case (paddr[2])
            REG_START_TIME: start_time_ff <= pwdata;
            REG_DURATION:   duration_ff   <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_START_TIME: prdata = start_time_ff;
         REG_DURATION:   prdata = duration_ff;
         default:        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      d2_ff <= d_eff * d_eff;
   end

   // input stage: window test and offset into the window
   logic              a_vld_ff;
   base_type          a_b_ff;
   logic [DATA_W-1:0] a_e_ff;
   logic [DATA_W:0]   win_end;

   assign win_end = {1'b0, start_time_ff} + {1'b0, d_eff};

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (adv) begin
         a_vld_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_b_ff.prior  <= req_chan.sample_time < start_time_ff;
         a_b_ff.after  <= {1'b0, req_chan.sample_time} > win_end;
         a_b_ff.q0     <= req_chan.joint_start;
         a_b_ff.q1     <= req_chan.joint_end;
         a_b_ff.delta  <= {req_chan.joint_end[DATA_W-1], req_chan.joint_end}
                          - {req_chan.joint_start[DATA_W-1], req_chan.joint_start};
         a_b_ff.last   <= req_chan.last_joint;
         a_e_ff        <= req_chan.sample_time - start_time_ff;
      end
   end

   // tau = offset * 2^24 / duration, one quotient bit per stage
   logic              tv_ff [0:TAU_W-1];
   base_type          tb_ff [0:TAU_W-1];
   logic [DATA_W-1:0] tr_ff [0:TAU_W-1];
   logic [TAU_W-1:0]  tq_ff [0:TAU_W-1];

   for (genvar k = 0; k < TAU_W; k++) begin : g_tau
      logic              v_prev;
      base_type          b_prev;
      logic [DATA_W:0]   trial;
      logic [DATA_W:0]   diff;
      logic [TAU_W-1:0]  q_prev;
      logic              hit;

      if (k == 0) begin : g_first
         assign v_prev = a_vld_ff;
         assign b_prev = a_b_ff;
         assign trial  = {1'b0, a_e_ff};
         assign q_prev = '0;
      end else begin : g_next
         assign v_prev = tv_ff[k-1];
         assign b_prev = tb_ff[k-1];
         assign trial  = {tr_ff[k-1], 1'b0};
         assign q_prev = tq_ff[k-1];
      end

      assign hit  = trial >= {1'b0, d_eff};
      assign diff = trial - {1'b0, d_eff};

      always_ff @(posedge clock) begin
         if (reset) begin
            tv_ff[k] <= 1'b0;
         end else if (adv) begin
            tv_ff[k] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            tb_ff[k] <= b_prev;
            tr_ff[k] <= hit ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
            tq_ff[k] <= {q_prev[TAU_W-2:0], hit};
         end
      end
   end

   // powers of tau, one product per stage
   localparam int PW_N = POW_N - 1;

   logic     pv_ff [0:PW_N-1];
   base_type pb_ff [0:PW_N-1];
   pow_type  pw_ff [0:PW_N-1];

   for (genvar k = 0; k < PW_N; k++) begin : g_pow
      logic             v_prev;
      base_type         b_prev;
      pow_type          w_prev;
      pow_type          w_next;
      logic [2*TAU_W-1:0] prod;

      if (k == 0) begin : g_first
         assign v_prev = tv_ff[TAU_W-1];
         assign b_prev = tb_ff[TAU_W-1];
         assign w_prev = {{(PW_N*TAU_W){1'b0}}, tq_ff[TAU_W-1]};
      end else begin : g_next
         assign v_prev = pv_ff[k-1];
         assign b_prev = pb_ff[k-1];
         assign w_prev = pw_ff[k-1];
      end

      always_comb begin
         prod        = w_prev[k] * w_prev[0];
         w_next      = w_prev;
         w_next[k+1] = prod[FRAC_W+TAU_W-1:FRAC_W];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            pv_ff[k] <= 1'b0;
         end else if (adv) begin
            pv_ff[k] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            pb_ff[k] <= b_prev;
            pw_ff[k] <= w_next;
         end
      end
   end

   // polynomial stage
   logic               c_vld_ff;
   base_type           c_b_ff;
   logic [TAU_W-1:0]   c_s_ff;
   logic signed [27:0] c_p_ff;
   logic signed [29:0] c_r_ff;
   pow_type            pw_last;
   logic signed [33:0] x1, x2, x3, x4, x5;
   logic signed [33:0] s_raw, p_raw, r_raw;
   logic [TAU_W-1:0]   s_clamp;

   assign pw_last = pw_ff[PW_N-1];

   always_comb begin
      x1    = $signed({9'b0, pw_last[0]});
      x2    = $signed({9'b0, pw_last[1]});
      x3    = $signed({9'b0, pw_last[2]});
      x4    = $signed({9'b0, pw_last[3]});
      x5    = $signed({9'b0, pw_last[4]});
      s_raw = 34'sd10 * x3 - 34'sd15 * x4 + 34'sd6 * x5;
      p_raw = 34'sd30 * x2 - 34'sd60 * x3 + 34'sd30 * x4;
      r_raw = 34'sd60 * x1 - 34'sd180 * x2 + 34'sd120 * x3;
      if (s_raw < 0) begin
         s_clamp = '0;
      end else if (s_raw > $signed(34'd1 << FRAC_W)) begin
         s_clamp = {1'b1, {FRAC_W{1'b0}}};
      end else begin
         s_clamp = s_raw[TAU_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff <= 1'b0;
      end else if (adv) begin
         c_vld_ff <= pv_ff[PW_N-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c_b_ff <= pb_ff[PW_N-1];
         c_s_ff <= s_clamp;
         c_p_ff <= p_raw[27:0];
         c_r_ff <= r_raw[29:0];
      end
   end

   // span products
   logic               m_vld_ff;
   base_type           m_b_ff;
   logic signed [58:0] m_ps_ff;
   logic signed [60:0] m_pp_ff;
   logic signed [62:0] m_pr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m_vld_ff <= 1'b0;
      end else if (adv) begin
         m_vld_ff <= c_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m_b_ff  <= c_b_ff;
         m_ps_ff <= c_b_ff.delta * $signed({1'b0, c_s_ff});
         m_pp_ff <= c_b_ff.delta * c_p_ff;
         m_pr_ff <= c_b_ff.delta * c_r_ff;
      end
   end

   // position and sign/magnitude split for the rate divider
   logic               e_vld_ff;
   div_item_type       e_ff;
   logic signed [35:0] pos_sum;
   logic signed [DATA_W-1:0] pos_win;
   logic [60:0]        pp_abs;
   logic [62:0]        pr_abs;
   div_item_type       e_in;

   always_comb begin
      pos_sum = 36'(m_b_ff.q0) + 36'(m_ps_ff >>> FRAC_W);
      if (pos_sum > 36'sh07FFFFFFF) begin
         pos_win = {1'b0, {(DATA_W-1){1'b1}}};
      end else if (pos_sum < -36'sh080000000) begin
         pos_win = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         pos_win = pos_sum[DATA_W-1:0];
      end
      pp_abs      = m_pp_ff[60] ? 61'(-m_pp_ff) : 61'(m_pp_ff);
      pr_abs      = m_pr_ff[62] ? 63'(-m_pr_ff) : 63'(m_pr_ff);
      e_in.window = !m_b_ff.prior && !m_b_ff.after;
      e_in.last   = m_b_ff.last;
      e_in.pos    = m_b_ff.prior ? m_b_ff.q0 : (m_b_ff.after ? m_b_ff.q1 : pos_win);
      e_in.vsign  = m_pp_ff[60];
      e_in.asign  = m_pr_ff[62];
      e_in.vnum   = {{(DIV_W-37){1'b0}}, pp_abs[60:24]};
      e_in.anum   = pr_abs[62:8];
      e_in.vrem   = '0;
      e_in.arem   = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_vld_ff <= 1'b0;
      end else if (adv) begin
         e_vld_ff <= m_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e_ff <= e_in;
      end
   end

   // velocity by duration, acceleration by duration squared
   logic         dv_valid;
   div_item_type dv_item;

   mjt_div_pipe u_div (
      .clock       (clock),
      .reset       (reset),
      .advance     (adv),
      .in_valid    (e_vld_ff),
      .in_item     (e_ff),
      .vel_divisor ({{(DVS_W-DATA_W){1'b0}}, d_eff}),
      .acc_divisor (d2_ff),
      .out_valid   (dv_valid),
      .out_item    (dv_item)
   );

   // output register
   logic signed [DATA_W-1:0] pos_ff;
   logic signed [OUT_W-1:0]  vel_ff;
   logic signed [OUT_W-1:0]  acc_ff;
   logic                     last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pos_ff  <= dv_item.pos;
         vel_ff  <= dv_item.window ? sat_out(dv_item.vsign, dv_item.vnum) : '0;
         acc_ff  <= dv_item.window ? sat_out(dv_item.asign, dv_item.anum) : '0;
         last_ff <= dv_item.last;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.position     = pos_ff;
   assign rsp_chan.velocity     = vel_ff;
   assign rsp_chan.acceleration = acc_ff;
   assign rsp_chan.last_out     = last_ff;

endmodule

// ===== verif/tb.sv =====
module tb;
   import mjt_pkg::*;

   typedef struct packed {
      logic [31:0]        t;
      logic signed [31:0] q0;
      logic signed [31:0] q1;
      logic               last;
   } joint_sample_type;

   typedef struct packed {
      logic signed [31:0] pos;
      logic signed [47:0] vel;
      logic signed [47:0] acc;
      logic               last;
   } motion_type;

   typedef struct packed {
      joint_sample_type s;
      bit               fixed;
      motion_type       want;
   } directed_row_type;

   localparam longint SAT_HI = (64'sd1 <<< 47) - 1;
   localparam longint SAT_LO = -(64'sd1 <<< 47);
   localparam int     LIMIT  = 1_000_000;
   localparam int     DRAIN  = 100;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic psel, penable, pwrite;
   logic [ADDR_W-1:0] paddr;
   logic [31:0] pwdata, prdata;
   logic pready;

   mjt_req_if req();
   mjt_rsp_if rsp();

   minimum_jerk_trajectory_eval i_dut (
      .clock(clock), .reset(reset), .req_chan(req), .rsp_chan(rsp),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   logic [31:0] cfg_start = 0;
   logic [31:0] cfg_duration = 1;
   motion_type  expected_motion[$];
   int          errors = 0;
   int          cycles = 0;
   bit          idle_on = 1'b1;

   function automatic longint sat48(input longint x);
      if (x > SAT_HI) return SAT_HI;
      if (x < SAT_LO) return SAT_LO;
      return x;
   endfunction

   function automatic motion_type eval_quintic(input joint_sample_type in);
      longint unsigned d, ts, e;
      longint tau, t2, t3, t4, t5, delta, s, p, r, pos, vel, acc, dd, q0, q1;
      motion_type m;
      d   = (cfg_duration == 0) ? 1 : cfg_duration;
      ts  = cfg_start;
      q0  = in.q0;
      q1  = in.q1;
      vel = 0;
      acc = 0;
      if (in.t < ts) begin
         pos = q0;
      end else if (longint'(in.t) > longint'(ts + d)) begin
         pos = q1;
      end else begin
         e     = in.t - ts;
         tau   = longint'((e << 24) / d);
         t2    = (tau * tau) >>> 24;
         t3    = (t2 * tau) >>> 24;
         t4    = (t3 * tau) >>> 24;
         t5    = (t4 * tau) >>> 24;
         delta = q1 - q0;
         s     = 10 * t3 - 15 * t4 + 6 * t5;
         p     = 30 * t2 - 60 * t3 + 30 * t4;
         r     = 60 * tau - 180 * t2 + 120 * t3;
         dd    = longint'(d);
         if (s < 0) s = 0;
         if (s > (64'sd1 <<< 24)) s = 64'sd1 <<< 24;
         // arithmetic shift gives the floor
         pos = q0 + ((delta * s) >>> 24);
         if (pos > 64'sd2147483647) pos = 64'sd2147483647;
         if (pos < -64'sd2147483648) pos = -64'sd2147483648;
         vel = sat48((delta * p) / (dd * (64'sd1 <<< 24)));
         acc = sat48(((delta * r) / dd) / (dd * 256));
      end
      m.pos  = pos[31:0];
      m.vel  = vel[47:0];
      m.acc  = acc[47:0];
      m.last = in.last;
      return m;
   endfunction

   // result side: random stalls, compare against oldest expectation
   always @(posedge clock) begin
      motion_type want;
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("** minimum_jerk_trajectory_eval: FAILED **");
         $finish;
      end
      if (!reset && rsp.valid && rsp.ready) begin
         if (expected_motion.size() == 0) begin
            $error("unexpected result item, position %h", rsp.position);
            errors = errors + 1;
         end else begin
            want = expected_motion.pop_front();
            if (rsp.position !== want.pos) begin
               $error("position: expected %h, got %h", want.pos, rsp.position);
               errors = errors + 1;
            end
            if (rsp.velocity !== want.vel) begin
               $error("velocity: expected %h, got %h", want.vel, rsp.velocity);
               errors = errors + 1;
            end
            if (rsp.acceleration !== want.acc) begin
               $error("acceleration: expected %h, got %h", want.acc, rsp.acceleration);
               errors = errors + 1;
            end
            if (rsp.last_out !== want.last) begin
               $error("last_out: expected %b, got %b", want.last, rsp.last_out);
               errors = errors + 1;
            end
         end
      end
      rsp.ready <= idle_on ? ($urandom_range(99) >= 19) : 1'b1;
   end

   task automatic send_joint(input joint_sample_type s, input bit fixed,
                             input motion_type want);
      while (idle_on && $urandom_range(99) < 19) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid       <= 1'b1;
      req.sample_time <= s.t;
      req.joint_start <= s.q0;
      req.joint_end   <= s.q1;
      req.last_joint  <= s.last;
      do @(posedge clock); while (!req.ready);
      expected_motion.push_back(fixed ? want : eval_quintic(s));
   endtask

   task automatic drain_results();
      while (expected_motion.size() != 0) @(posedge clock);
   endtask

   // pipeline must be empty before a register changes
   task automatic write_reg(input logic idx, input logic [31:0] value);
      req.valid <= 1'b0;
      @(posedge clock);
      drain_results();
      repeat (DRAIN) @(posedge clock);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (idx == REG_START_TIME) cfg_start = value;
      else cfg_duration = value;
   endtask

   function automatic joint_sample_type random_joint();
      joint_sample_type s;
      longint unsigned d, room;
      int pick;
      d    = (cfg_duration == 0) ? 1 : cfg_duration;
      room = 64'hFFFF_FFFF - cfg_start;
      if (room > d) room = d;
      pick = $urandom_range(99);
      if (pick < 70) begin
         s.t = cfg_start + ((room < 64'hFFFF_FFFF) ? $urandom_range(0, int'(room)) : $urandom);
         if (room > 64'h7FFF_FFFF) s.t = cfg_start + 32'($urandom % (room + 1));
      end else if (pick < 85) begin
         s.t = $urandom;
      end else begin
         // around the window edges
         case ($urandom_range(3))
            0: s.t = cfg_start;
            1: s.t = cfg_start - 1;
            2: s.t = cfg_start + 32'(room);
            default: s.t = cfg_start + 32'(room) + 32'd1;
         endcase
      end
      s.q0 = $urandom;
      if ($urandom_range(9) < 3) s.q1 = s.q0 + $signed($urandom_range(0, 8191)) - 4096;
      else s.q1 = $urandom;
      s.last = ($urandom_range(3) == 0);
      return s;
   endfunction

   directed_row_type plan[$];
   motion_type zero_want;

   initial begin
      logic [31:0] starts[10];
      logic [31:0] durs[10];
      joint_sample_type s;
      directed_row_type row;
      req.valid       = 1'b0;
      req.sample_time = '0;
      req.joint_start = '0;
      req.joint_end   = '0;
      req.last_joint  = 1'b0;
      rsp.ready       = 1'b0;
      psel            = 1'b0;
      penable         = 1'b0;
      pwrite          = 1'b0;
      paddr           = '0;
      pwdata          = '0;
      zero_want       = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // defaults after reset: window [0,1]
      send_joint('{32'd5, 32'sd100, -32'sd100, 1'b1}, 1'b1,
                 '{-32'sd100, 48'sd0, 48'sd0, 1'b1});
      send_joint('{32'd0, 32'sd7, 32'sd9, 1'b0}, 1'b1, '{32'sd7, 48'sd0, 48'sd0, 1'b0});

      write_reg(REG_START_TIME, 32'd1000);
      write_reg(REG_DURATION, 32'd100);
      // sample, start, end, last, fixed?, expected
      plan = '{
         '{'{32'd0, 32'sh1234_5678, 32'sh0000_0001, 1'b0}, 1'b1,
           '{32'sh1234_5678, 48'sd0, 48'sd0, 1'b0}},
         '{'{32'd999, -32'sd2147483648, 32'sd2147483647, 1'b1}, 1'b1,
           '{-32'sd2147483648, 48'sd0, 48'sd0, 1'b1}},
         '{'{32'd1000, 32'sd2147483647, -32'sd2147483648, 1'b0}, 1'b1,
           '{32'sd2147483647, 48'sd0, 48'sd0, 1'b0}},
         '{'{32'd1100, -32'sd2147483648, 32'sd2147483647, 1'b1}, 1'b1,
           '{32'sd2147483647, 48'sd0, 48'sd0, 1'b1}},
         '{'{32'd1101, 32'sd5, -32'sd6, 1'b0}, 1'b1, '{-32'sd6, 48'sd0, 48'sd0, 1'b0}},
         '{'{32'hFFFF_FFFF, 32'sd0, 32'sh7FFF_0000, 1'b1}, 1'b1,
           '{32'sh7FFF_0000, 48'sd0, 48'sd0, 1'b1}},
         '{'{32'd1050, -32'sd2147483648, 32'sd2147483647, 1'b0}, 1'b0, zero_want},
         '{'{32'd1050, 32'sd2147483647, -32'sd2147483648, 1'b1}, 1'b0, zero_want},
         '{'{32'd1001, -32'sd2147483648, 32'sd2147483647, 1'b0}, 1'b0, zero_want},
         '{'{32'd1099, 32'sd2147483647, -32'sd2147483648, 1'b0}, 1'b0, zero_want},
         '{'{32'd1020, 32'sd65536, 32'sd65536, 1'b0}, 1'b0, zero_want},
         '{'{32'd1075, -32'sd1, 32'sd0, 1'b1}, 1'b0, zero_want}
      };
      foreach (plan[i]) send_joint(plan[i].s, plan[i].fixed, plan[i].want);

      // zero duration acts as one tick; huge duration and top start
      write_reg(REG_DURATION, 32'd0);
      send_joint('{32'd1001, 32'sd0, 32'sd100, 1'b0}, 1'b0, zero_want);
      send_joint('{32'd1002, 32'sd0, 32'sd100, 1'b1}, 1'b1, '{32'sd100, 48'sd0, 48'sd0, 1'b1});
      write_reg(REG_START_TIME, 32'hFFFF_FFFF);
      write_reg(REG_DURATION, 32'hFFFF_FFFF);
      send_joint('{32'hFFFF_FFFF, 32'sd1, 32'sd2, 1'b0}, 1'b1, '{32'sd1, 48'sd0, 48'sd0, 1'b0});
      send_joint('{32'hFFFF_FFFE, 32'sd1, 32'sd2, 1'b1}, 1'b1, '{32'sd1, 48'sd0, 48'sd0, 1'b1});

      starts = '{32'd0, 32'd0, 32'd500, 32'hFFFF_FFFF, 32'hFFFF_F000, 32'd0,
                 32'd12345, 32'h8000_0000, 32'd3, 32'd77};
      durs   = '{32'd1, 32'hFFFF_FFFF, 32'd2, 32'd10, 32'd7, 32'd1000,
                 32'd0, 32'h0100_0000, 32'd333, 32'd65536};
      for (int ph = 0; ph < 10; ph++) begin
         if (ph == 3) starts[ph] = $urandom;
         if (ph == 8) durs[ph] = $urandom;
         write_reg(REG_START_TIME, starts[ph]);
         write_reg(REG_DURATION, durs[ph]);
         idle_on = (ph != 5);
         for (int n = 0; n < 150; n++) begin
            if (ph == 2 && n == 75) begin
               req.valid <= 1'b0;
               @(posedge clock);
               drain_results();
            end
            s = random_joint();
            send_joint(s, 1'b0, zero_want);
         end
      end

      req.valid <= 1'b0;
      idle_on = 1'b1;
      drain_results();
      repeat (DRAIN) @(posedge clock);
      if (errors == 0) begin
         $display("** minimum_jerk_trajectory_eval: PASSED **");
      end else begin
         $display("** minimum_jerk_trajectory_eval: FAILED **");
      end
      $finish;
   end

endmodule
